// File: rtl/hsv_to_rgb_converter_unit_macros.svh
// assertion macros for the hsv to rgb converter checker
// no dependencies; included by the checker file only
`ifndef HSV_TO_RGB_CONVERTER_UNIT_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_UNIT_MACROS_SVH

// property checked on every clock edge outside reset
`define HSVRGB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every clock edge, reset included
`define HSVRGB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/hsvrgb_pkg.sv
// shared widths, constants and sector codes for the hsv to rgb converter
// no dependencies
package hsvrgb_pkg;

    localparam int HUE_W    = 9;
    localparam int CH_W     = 8;
    localparam int REM_W    = 6;
    localparam int NUM_W    = 14;
    localparam int XQT_W    = CH_W + NUM_W;
    localparam int XP_W     = 2 * CH_W;

    localparam int SECTOR_DEG = 60;
    localparam int TURN_DEG   = 360;
    localparam int FULL_SCALE = 255;
    localparam int DEN_QT     = FULL_SCALE * SECTOR_DEG;

    // reciprocal of 15300 scaled by 2^32, floor
    localparam int RECIP_QT_W = 19;
    localparam int SHIFT_QT   = 32;
    localparam logic [RECIP_QT_W-1:0] RECIP_QT = RECIP_QT_W'(280716);

    // reciprocal of 255 scaled by 2^24, floor
    localparam int RECIP_P_W = 17;
    localparam int SHIFT_P   = 24;
    localparam logic [RECIP_P_W-1:0] RECIP_P = RECIP_P_W'(65793);

    localparam int PROD_QT_W = XQT_W + RECIP_QT_W;
    localparam int PROD_P_W  = XP_W + RECIP_P_W;

    typedef enum logic [2:0] {
        SECT_RED_YELLOW    = 3'd0,
        SECT_YELLOW_GREEN  = 3'd1,
        SECT_GREEN_CYAN    = 3'd2,
        SECT_CYAN_BLUE     = 3'd3,
        SECT_BLUE_MAGENTA  = 3'd4,
        SECT_MAGENTA_RED   = 3'd5
    } sector_t;

endpackage

// File: rtl/hsv_to_rgb_converter_unit.sv
// hsv to rgb converter, five-stage pipeline, top level
// depends on hsvrgb_pkg
//
// usage
//   input word: hue_degrees (0..359, 360..511 wraps one turn), saturation and
//   brightness_value (8-bit fractions, 255 is 1.0). a word is taken at a rising
//   edge with start high and busy low. busy stays low: the pipeline takes a
//   new word every cycle.
//   result word: red, green, blue, shown for exactly one cycle with done high.
//   the receiver cannot stall, so no backpressure exists and none is needed.
// pipeline
//   a word taken at an edge passes the five register stages in order: hue split,
//   numerators, value products, reciprocal products, then correction and channel
//   select. done rises together with the result. one word per clock.
// reset
//   rst_n clears the valid bits of every stage, so no done follows reset;
//   the data registers are not reset. there is no other state.
module hsv_to_rgb_converter_unit
    import hsvrgb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [HUE_W-1:0]  hue_degrees,
    input  logic [CH_W-1:0]   saturation,
    input  logic [CH_W-1:0]   brightness_value,
    output logic              done,
    output logic [CH_W-1:0]   red,
    output logic [CH_W-1:0]   green,
    output logic [CH_W-1:0]   blue
);

    localparam logic [HUE_W-1:0] HUE_TURN  = HUE_W'(TURN_DEG);
    localparam logic [HUE_W-1:0] HUE_60    = HUE_W'(SECTOR_DEG);
    localparam logic [HUE_W-1:0] HUE_120   = HUE_W'(2 * SECTOR_DEG);
    localparam logic [HUE_W-1:0] HUE_180   = HUE_W'(3 * SECTOR_DEG);
    localparam logic [HUE_W-1:0] HUE_240   = HUE_W'(4 * SECTOR_DEG);
    localparam logic [HUE_W-1:0] HUE_300   = HUE_W'(5 * SECTOR_DEG);
    localparam logic [REM_W-1:0] REM_SPAN  = REM_W'(SECTOR_DEG);
    localparam logic [NUM_W-1:0] NUM_DEN   = NUM_W'(DEN_QT);
    localparam logic [CH_W-1:0]  CH_FULL   = CH_W'(FULL_SCALE);
    localparam logic [XQT_W-1:0] XQT_DEN   = XQT_W'(DEN_QT);
    localparam logic [XP_W-1:0]  XP_DEN    = XP_W'(FULL_SCALE);

    // the pipeline never holds off a word
    assign busy = 1'b0;

    // valid bits, one per stage
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, done_reg;

    // stage 1: wrap hue and split into sector and remainder
    logic [HUE_W-1:0] hue_wrap;
    logic [HUE_W-1:0] sect_base;
    logic [HUE_W-1:0] rem_full;
    sector_t          sect_next;
    logic [REM_W-1:0] rem_next;

    sector_t          s1_sect_reg;
    logic [REM_W-1:0] s1_rem_reg;
    logic [CH_W-1:0]  s1_sat_reg;
    logic [CH_W-1:0]  s1_val_reg;

    assign hue_wrap = (hue_degrees >= HUE_TURN) ? hue_degrees - HUE_TURN : hue_degrees;

    always_comb
    begin
        if (hue_wrap < HUE_60)
        begin
            sect_next = SECT_RED_YELLOW;
            sect_base = '0;
        end
        else if (hue_wrap < HUE_120)
        begin
            sect_next = SECT_YELLOW_GREEN;
            sect_base = HUE_60;
        end
        else if (hue_wrap < HUE_180)
        begin
            sect_next = SECT_GREEN_CYAN;
            sect_base = HUE_120;
        end
        else if (hue_wrap < HUE_240)
        begin
            sect_next = SECT_CYAN_BLUE;
            sect_base = HUE_180;
        end
        else if (hue_wrap < HUE_300)
        begin
            sect_next = SECT_BLUE_MAGENTA;
            sect_base = HUE_240;
        end
        else
        begin
            sect_next = SECT_MAGENTA_RED;
            sect_base = HUE_300;
        end
    end

    assign rem_full = hue_wrap - sect_base;
    assign rem_next = rem_full[REM_W-1:0];

    // stage 2: numerators of p, q and t
    logic [NUM_W-1:0] sr_q, sr_t;
    logic [REM_W-1:0] rem_c;
    logic [NUM_W-1:0] num_q_next, num_t_next;
    logic [CH_W-1:0]  num_p_next;

    sector_t          s2_sect_reg;
    logic [CH_W-1:0]  s2_val_reg;
    logic [NUM_W-1:0] s2_num_q_reg, s2_num_t_reg;
    logic [CH_W-1:0]  s2_num_p_reg;

    assign rem_c      = REM_SPAN - s1_rem_reg;
    assign sr_q       = NUM_W'(s1_sat_reg) * NUM_W'(s1_rem_reg);
    assign sr_t       = NUM_W'(s1_sat_reg) * NUM_W'(rem_c);
    assign num_q_next = NUM_DEN - sr_q;
    assign num_t_next = NUM_DEN - sr_t;
    assign num_p_next = CH_FULL - s1_sat_reg;

    // stage 3: scale by value
    logic [XQT_W-1:0] xq_next, xt_next;
    logic [XP_W-1:0]  xp_next;

    sector_t          s3_sect_reg;
    logic [CH_W-1:0]  s3_val_reg;
    logic [XQT_W-1:0] s3_xq_reg, s3_xt_reg;
    logic [XP_W-1:0]  s3_xp_reg;

    assign xq_next = XQT_W'(s2_val_reg) * XQT_W'(s2_num_q_reg);
    assign xt_next = XQT_W'(s2_val_reg) * XQT_W'(s2_num_t_reg);
    assign xp_next = XP_W'(s2_val_reg) * XP_W'(s2_num_p_reg);

    // stage 4: quotient estimate by reciprocal, never above the true quotient
    // and at most one below it
    logic [PROD_QT_W-1:0] pq_prod, pt_prod;
    logic [PROD_P_W-1:0]  pp_prod;

    sector_t          s4_sect_reg;
    logic [CH_W-1:0]  s4_val_reg;
    logic [XQT_W-1:0] s4_xq_reg, s4_xt_reg;
    logic [XP_W-1:0]  s4_xp_reg;
    logic [CH_W-1:0]  s4_eq_reg, s4_et_reg, s4_ep_reg;

    assign pq_prod = PROD_QT_W'(s3_xq_reg) * PROD_QT_W'(RECIP_QT);
    assign pt_prod = PROD_QT_W'(s3_xt_reg) * PROD_QT_W'(RECIP_QT);
    assign pp_prod = PROD_P_W'(s3_xp_reg) * PROD_P_W'(RECIP_P);

    // stage 5: correct the estimates, pick channel order
    logic [XQT_W-1:0] rq, rt;
    logic [XP_W-1:0]  rp;
    logic [CH_W-1:0]  q_val, t_val, p_val;
    logic [CH_W-1:0]  red_next, green_next, blue_next;
    logic [CH_W-1:0]  red_reg, green_reg, blue_reg;

    assign rq = s4_xq_reg - XQT_W'(s4_eq_reg) * XQT_DEN;
    assign rt = s4_xt_reg - XQT_W'(s4_et_reg) * XQT_DEN;
    assign rp = s4_xp_reg - XP_W'(s4_ep_reg) * XP_DEN;

    assign q_val = s4_eq_reg + CH_W'(rq >= XQT_DEN);
    assign t_val = s4_et_reg + CH_W'(rt >= XQT_DEN);
    assign p_val = s4_ep_reg + CH_W'(rp >= XP_DEN);

    // zero saturation makes p, q and t equal value, so grey needs no bypass
    always_comb
    begin
        case (s4_sect_reg)
            SECT_RED_YELLOW:
            begin
                red_next   = s4_val_reg;
                green_next = t_val;
                blue_next  = p_val;
            end
            SECT_YELLOW_GREEN:
            begin
                red_next   = q_val;
                green_next = s4_val_reg;
                blue_next  = p_val;
            end
            SECT_GREEN_CYAN:
            begin
                red_next   = p_val;
                green_next = s4_val_reg;
                blue_next  = t_val;
            end
            SECT_CYAN_BLUE:
            begin
                red_next   = p_val;
                green_next = q_val;
                blue_next  = s4_val_reg;
            end
            SECT_BLUE_MAGENTA:
            begin
                red_next   = t_val;
                green_next = p_val;
                blue_next  = s4_val_reg;
            end
            default:
            begin
                red_next   = s4_val_reg;
                green_next = p_val;
                blue_next  = q_val;
            end
        endcase
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start & ~busy;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            done_reg     <= s4_valid_reg;
        end
    end

    // data registers, no reset
    always_ff @(posedge clk)
    begin
        s1_sect_reg  <= sect_next;
        s1_rem_reg   <= rem_next;
        s1_sat_reg   <= saturation;
        s1_val_reg   <= brightness_value;

        s2_sect_reg  <= s1_sect_reg;
        s2_val_reg   <= s1_val_reg;
        s2_num_q_reg <= num_q_next;
        s2_num_t_reg <= num_t_next;
        s2_num_p_reg <= num_p_next;

        s3_sect_reg  <= s2_sect_reg;
        s3_val_reg   <= s2_val_reg;
        s3_xq_reg    <= xq_next;
        s3_xt_reg    <= xt_next;
        s3_xp_reg    <= xp_next;

        s4_sect_reg  <= s3_sect_reg;
        s4_val_reg   <= s3_val_reg;
        s4_xq_reg    <= s3_xq_reg;
        s4_xt_reg    <= s3_xt_reg;
        s4_xp_reg    <= s3_xp_reg;
        s4_eq_reg    <= pq_prod[SHIFT_QT+CH_W-1:SHIFT_QT];
        s4_et_reg    <= pt_prod[SHIFT_QT+CH_W-1:SHIFT_QT];
        s4_ep_reg    <= pp_prod[SHIFT_P+CH_W-1:SHIFT_P];

        red_reg      <= red_next;
        green_reg    <= green_next;
        blue_reg     <= blue_next;
    end

    assign done  = done_reg;
    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

// File: rtl/hsvrgb_checker.sv
// port-level checker for the hsv to rgb converter, bound to the top level
// depends on hsvrgb_pkg and hsv_to_rgb_converter_unit_macros.svh
`include "hsv_to_rgb_converter_unit_macros.svh"

module hsvrgb_checker
    import hsvrgb_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic [HUE_W-1:0]  hue_degrees,
    input logic [CH_W-1:0]   saturation,
    input logic [CH_W-1:0]   brightness_value,
    input logic              done,
    input logic [CH_W-1:0]   red,
    input logic [CH_W-1:0]   green,
    input logic [CH_W-1:0]   blue
);

    logic take;
    assign take = start & ~busy;

    // zero saturation gives grey at the value level
    property p_grey;
        take && saturation == '0 |-> ##5
            (red == $past(brightness_value, 5) && green == red && blue == red);
    endproperty

    // the largest channel is the value, and none exceeds it
    property p_max_is_value;
        take |-> ##5
            ((red == $past(brightness_value, 5) || green == $past(brightness_value, 5)
              || blue == $past(brightness_value, 5))
             && red <= $past(brightness_value, 5) && green <= $past(brightness_value, 5)
             && blue <= $past(brightness_value, 5));
    endproperty

    // every accepted word comes out with done high, and nothing else does
    `HSVRGB_ASSERT(a_latency, take |-> ##5 done, "accepted word produced no result")
    `HSVRGB_ASSERT(a_no_spurious, !take |-> ##5 !done, "result without accepted word")

    `HSVRGB_ASSERT(a_grey, p_grey, "grey mismatch")

    `HSVRGB_ASSERT(a_max_is_value, p_max_is_value, "channel above value or value missing")

    // the pipeline never refuses a word
    `HSVRGB_ASSERT_ALWAYS(a_never_busy, !busy, "busy raised")

endmodule

bind hsv_to_rgb_converter_unit hsvrgb_checker u_hsvrgb_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .hue_degrees      (hue_degrees),
    .saturation       (saturation),
    .brightness_value (brightness_value),
    .done             (done),
    .red              (red),
    .green            (green),
    .blue             (blue)
);

// File: test/hsv_to_rgb_converter_unit_tb.sv
// self-checking testbench for the hsv to rgb converter: directed corner pixels,
// then random pixel streams at three sender gap rates, checked against a predictor
// depends on hsvrgb_pkg and the hsv_to_rgb_converter_unit rtl
module hsv_to_rgb_converter_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import hsvrgb_pkg::*;

    // one result word as the block shows it
    typedef struct packed {
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
    } rgb_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [HUE_W-1:0]  hue_degrees = '0;
    logic [CH_W-1:0]   saturation = '0;
    logic [CH_W-1:0]   brightness_value = '0;
    logic              done;
    logic [CH_W-1:0]   red;
    logic [CH_W-1:0]   green;
    logic [CH_W-1:0]   blue;

    // colors predicted for accepted words, oldest first
    rgb_t pending_rgb[$];
    int   error_count = 0;
    // chance in a hundred that the sender holds start low before a word
    int   gap_pct = 0;

    hsv_to_rgb_converter_unit u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .hue_degrees      (hue_degrees),
        .saturation       (saturation),
        .brightness_value (brightness_value),
        .done             (done),
        .red              (red),
        .green            (green),
        .blue             (blue)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // truncating hsv to rgb conversion at the block's widths
    function automatic rgb_t predict_rgb(logic [HUE_W-1:0] hue, logic [CH_W-1:0] sat,
                                         logic [CH_W-1:0] val);
        int unsigned h;
        int unsigned s;
        int unsigned v;
        int unsigned rem;
        int unsigned p;
        int unsigned q;
        int unsigned t;
        sector_t     sect;
        rgb_t        res;
        h = 32'(hue);
        s = 32'(sat);
        v = 32'(val);
        // hues past a full turn fold back one turn
        if (h >= TURN_DEG)
            h -= TURN_DEG;
        // no saturation means grey at the value level
        if (s == 0)
            return '{r: val, g: val, b: val};
        sect = sector_t'(h / SECTOR_DEG);
        rem  = h % SECTOR_DEG;
        p = v * (FULL_SCALE - s) / FULL_SCALE;
        q = v * (DEN_QT - s * rem) / DEN_QT;
        t = v * (DEN_QT - s * (SECTOR_DEG - rem)) / DEN_QT;
        case (sect)
            SECT_RED_YELLOW:   res = '{r: v[7:0], g: t[7:0], b: p[7:0]};
            SECT_YELLOW_GREEN: res = '{r: q[7:0], g: v[7:0], b: p[7:0]};
            SECT_GREEN_CYAN:   res = '{r: p[7:0], g: v[7:0], b: t[7:0]};
            SECT_CYAN_BLUE:    res = '{r: p[7:0], g: q[7:0], b: v[7:0]};
            SECT_BLUE_MAGENTA: res = '{r: t[7:0], g: p[7:0], b: v[7:0]};
            default:           res = '{r: v[7:0], g: p[7:0], b: q[7:0]};
        endcase
        return res;
    endfunction

    function automatic void check_channel(string name, logic [CH_W-1:0] exp_val,
                                          logic [CH_W-1:0] act_val);
        if (act_val !== exp_val)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, act_val);
        end
    endfunction

    // one process watches both sides at each edge
    // the result side is handled before the input side: the pipeline is five deep,
    // so a word accepted at this edge can never be the one finishing here
    always @(posedge clk)
    begin
        rgb_t exp_rgb;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_rgb.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result word, got r=%0d g=%0d b=%0d",
                             $time, red, green, blue);
                end
                else
                begin
                    exp_rgb = pending_rgb.pop_front();
                    check_channel("red", exp_rgb.r, red);
                    check_channel("green", exp_rgb.g, green);
                    check_channel("blue", exp_rgb.b, blue);
                end
            end
            // a word is taken whenever start meets a low busy
            if (start && !busy)
                pending_rgb.push_back(predict_rgb(hue_degrees, saturation, brightness_value));
        end
    end

    // sends one word; may first hold start low for a random gap with junk on the fields
    // start is left high on return, so back-to-back words keep it high without a dip
    task automatic send_pixel(logic [HUE_W-1:0] hue, logic [CH_W-1:0] sat,
                              logic [CH_W-1:0] val);
        while ($urandom_range(99) < gap_pct)
        begin
            start            <= 1'b0;
            hue_degrees      <= HUE_W'($urandom);
            saturation       <= CH_W'($urandom);
            brightness_value <= CH_W'($urandom);
            @(posedge clk);
        end
        start            <= 1'b1;
        hue_degrees      <= hue;
        saturation       <= sat;
        brightness_value <= val;
        // busy is sampled before the edge updates it, so this is the accepting edge
        do
            @(posedge clk);
        while (busy);
    endtask

    // full saturation and value at both ends of every sector, plus faint and dark pixels
    task automatic test_sector_corners();
        int corner_hues[13] = '{0, 1, 59, 60, 119, 120, 179, 180, 239, 240, 299, 300, 359};
        foreach (corner_hues[i])
            send_pixel(HUE_W'(corner_hues[i]), 8'd255, 8'd255);
        send_pixel(9'd30, 8'd1, 8'd255);
        send_pixel(9'd200, 8'd128, 8'd0);
    endtask

    // zero saturation at dark, middle and full value
    task automatic test_grey_levels();
        send_pixel(9'd0, 8'd0, 8'd0);
        send_pixel(9'd270, 8'd0, 8'd128);
        send_pixel(9'd511, 8'd0, 8'd255);
    endtask

    // hues beyond one turn, up to the largest the port carries
    task automatic test_hue_wrap();
        send_pixel(9'd360, 8'd255, 8'd255);
        send_pixel(9'd419, 8'd200, 8'd180);
        send_pixel(9'd480, 8'd77, 8'd255);
        send_pixel(9'd511, 8'd255, 8'd128);
    endtask

    // random pixels, mostly in range, with ends of the fraction fields favored
    task automatic test_random_pixels(int pct, int count);
        logic [HUE_W-1:0] hue;
        logic [CH_W-1:0]  sat;
        logic [CH_W-1:0]  val;
        gap_pct = pct;
        repeat (count)
        begin
            if ($urandom_range(99) < 15)
                hue = HUE_W'($urandom_range(511, 360));
            else
                hue = HUE_W'($urandom_range(359));
            case ($urandom_range(9))
                0:       sat = 8'd0;
                1:       sat = 8'd255;
                default: sat = CH_W'($urandom);
            endcase
            case ($urandom_range(9))
                0:       val = 8'd0;
                1:       val = 8'd255;
                default: val = CH_W'($urandom);
            endcase
            send_pixel(hue, sat, val);
        end
    endtask

    initial
    begin
        int drain_cycles;
        // hold reset, then release it on a rising edge
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_pct = 14;
        test_sector_corners();
        test_grey_levels();
        test_hue_wrap();

        // sender busy now and then, then mostly idle, then never idle
        test_random_pixels(14, 270);
        test_random_pixels(74, 270);
        test_random_pixels(0, 270);
        start <= 1'b0;

        // let the pipeline empty, then wait on to catch stray results
        drain_cycles = 0;
        while (pending_rgb.size() != 0 && drain_cycles < 100)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (8) @(posedge clk);
        if (pending_rgb.size() != 0)
        begin
            error_count++;
            $display("%0t: %0d result words never arrived", $time, pending_rgb.size());
        end

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/hsvrgb_pkg.sv
rtl/hsv_to_rgb_converter_unit.sv
rtl/hsvrgb_checker.sv
test/hsv_to_rgb_converter_unit_tb.sv
